// File: rtl/clmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmq_pkg
// Types, sizes and helpers shared by the cached lock manager queue.
// ----------------------------------------------------------------------------
package clmq_pkg;

    localparam int LOCK_ENTRIES = 16;
    localparam int WAITER_DEPTH = 16;

    localparam int ENTRY_W = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam int POS_W   = $clog2(WAITER_DEPTH);
    localparam int CNT_W   = $clog2(WAITER_DEPTH + 1);
    localparam int SLOTS   = LOCK_ENTRIES * WAITER_DEPTH;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int SLOT_W  = ENTRY_W + POS_W + 1;

    localparam logic       OP_ACQUIRE = 1'b0;
    localparam logic       OP_RELEASE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RETRY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [63:0] lock_id;
        logic [7:0]  client_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       send_revoke;
        logic       send_retry;
        logic [7:0] target_client;
    } out_item_t;

    // Next position in a lock's circular waiter queue
    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        if (p == POS_W'(WAITER_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + POS_W'(1);
        end
        return r;
    endfunction

    // Position count places after p, with count below WAITER_DEPTH
    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] p,
                                                 input logic [CNT_W-1:0] count);
        logic [POS_W:0] s;
        s = (POS_W + 1)'(p) + (POS_W + 1)'(count);
        if (s >= (POS_W + 1)'(WAITER_DEPTH)) begin
            s = s - (POS_W + 1)'(WAITER_DEPTH);
        end
        return s[POS_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [ENTRY_W-1:0] e,
                                                    input logic [POS_W-1:0] p);
        logic [SLOT_W-1:0] s;
        s = SLOT_W'(e) * SLOT_W'(WAITER_DEPTH) + SLOT_W'(p);
        return s[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/clmq_lock_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clmq_lock_table
// Lock entry table, key match and waiter queues; answers one item per cycle while fire is high.
// ----------------------------------------------------------------------------
module clmq_lock_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  clmq_pkg::in_item_t  item,
    output clmq_pkg::out_item_t result
);

    localparam int LE = clmq_pkg::LOCK_ENTRIES;
    localparam int EW = clmq_pkg::ENTRY_W;
    localparam int PW = clmq_pkg::POS_W;
    localparam int CW = clmq_pkg::CNT_W;
    localparam int AW = clmq_pkg::ADDR_W;

    logic          valid_reg   [LE];
    logic [63:0]   key_reg     [LE];
    logic [PW-1:0] head_reg    [LE];
    logic [CW-1:0] count_reg   [LE];
    // head client and the one behind it, cached per entry
    logic [7:0]    head_cl_reg [LE];
    logic [7:0]    next_cl_reg [LE];

    logic [7:0]    waiter_mem  [clmq_pkg::SLOTS];
    logic [7:0]    rdata_reg;
    logic          pend_reg;
    logic [EW-1:0] pend_idx_reg;

    logic          hit_found, free_found;
    logic [EW-1:0] hit_idx, free_idx;
    logic [PW-1:0] cur_head;
    logic [CW-1:0] cur_count;
    logic [7:0]    cur_head_cl, cur_next;
    logic [CW-1:0] new_cnt, pop_cnt;
    logic [PW-1:0] pop_head, tail_pos;

    logic          upd_en, upd_valid;
    logic [EW-1:0] upd_idx;
    logic [PW-1:0] upd_head;
    logic [CW-1:0] upd_count;
    logic          key_we, head_cl_we, next_cl_we, mem_we, rd_en;
    logic [7:0]    head_cl_val;
    logic [AW-1:0] mem_waddr, rd_addr;

    // lowest matching entry and lowest free entry
    always_comb begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int e = LE - 1; e >= 0; e--) begin
            if (valid_reg[e] && key_reg[e] == item.lock_id) begin
                hit_found = 1'b1;
                hit_idx   = EW'(e);
            end
            if (!valid_reg[e]) begin
                free_found = 1'b1;
                free_idx   = EW'(e);
            end
        end
    end

    assign cur_head    = head_reg[hit_idx];
    assign cur_count   = count_reg[hit_idx];
    assign cur_head_cl = head_cl_reg[hit_idx];
    // take the refill still in flight for this entry
    assign cur_next    = (pend_reg && pend_idx_reg == hit_idx) ? rdata_reg
                                                               : next_cl_reg[hit_idx];

    assign new_cnt  = cur_count + CW'(1);
    assign tail_pos = clmq_pkg::pos_add(cur_head, cur_count);
    assign pop_head = (cur_count != '0) ? clmq_pkg::pos_inc(cur_head) : cur_head;
    assign pop_cnt  = (cur_count != '0) ? cur_count - CW'(1) : cur_count;

    always_comb begin
        result      = '0;
        upd_en      = 1'b0;
        upd_idx     = hit_idx;
        upd_valid   = 1'b1;
        upd_head    = cur_head;
        upd_count   = cur_count;
        key_we      = 1'b0;
        head_cl_we  = 1'b0;
        head_cl_val = item.client_index;
        next_cl_we  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = clmq_pkg::slot_addr(hit_idx, tail_pos);
        rd_en       = 1'b0;
        rd_addr     = clmq_pkg::slot_addr(hit_idx, clmq_pkg::pos_inc(pop_head));
        result.status = clmq_pkg::STATUS_OK;

        if (item.operation == clmq_pkg::OP_ACQUIRE) begin
            if (!hit_found) begin
                if (!free_found) begin
                    result.status = clmq_pkg::STATUS_FULL;
                end else begin
                    upd_en     = 1'b1;
                    upd_idx    = free_idx;
                    upd_head   = '0;
                    upd_count  = CW'(1);
                    key_we     = 1'b1;
                    head_cl_we = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = clmq_pkg::slot_addr(free_idx, '0);
                    result.target_client = item.client_index;
                end
            end else if (cur_count >= CW'(clmq_pkg::WAITER_DEPTH)) begin
                result.status = clmq_pkg::STATUS_FULL;
            end else begin
                upd_en    = 1'b1;
                upd_count = new_cnt;
                mem_we    = 1'b1;
                result.target_client = cur_head_cl;
                if (new_cnt > CW'(1)) begin
                    result.status = clmq_pkg::STATUS_RETRY;
                end
                if (new_cnt == CW'(2)) begin
                    result.send_revoke = 1'b1;
                    next_cl_we         = 1'b1;
                end
            end
        end else if (hit_found) begin
            upd_en = 1'b1;
            if (pop_cnt != '0) begin
                upd_head    = pop_head;
                upd_count   = pop_cnt;
                head_cl_we  = 1'b1;
                head_cl_val = cur_next;
                result.target_client = cur_next;
                result.send_retry    = 1'b1;
                if (pop_cnt > CW'(1)) begin
                    result.send_revoke = 1'b1;
                    // fetch the new second waiter for the cache
                    rd_en = 1'b1;
                end
            end else begin
                upd_valid = 1'b0;
                upd_head  = '0;
                upd_count = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            for (int e = 0; e < LE; e++) begin
                valid_reg[e] <= 1'b0;
                head_reg[e]  <= '0;
                count_reg[e] <= '0;
            end
        end else begin
            pend_reg <= fire && rd_en;
            if (fire && upd_en) begin
                valid_reg[upd_idx] <= upd_valid;
                head_reg[upd_idx]  <= upd_head;
                count_reg[upd_idx] <= upd_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && key_we) begin
            key_reg[upd_idx] <= item.lock_id;
        end
        if (fire && head_cl_we) begin
            head_cl_reg[upd_idx] <= head_cl_val;
        end
        if (pend_reg) begin
            next_cl_reg[pend_idx_reg] <= rdata_reg;
        end
        if (fire && next_cl_we) begin
            next_cl_reg[upd_idx] <= item.client_index;
        end
        if (fire && rd_en) begin
            pend_idx_reg <= hit_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && mem_we) begin
            waiter_mem[mem_waddr] <= item.client_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && rd_en) begin
            rdata_reg <= waiter_mem[rd_addr];
        end
    end

    a_full_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.status == clmq_pkg::STATUS_FULL |->
            !result.send_revoke && !result.send_retry && result.target_client == 8'd0)
        else $error("FULL answer carries a message");

    a_refill_live: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> valid_reg[pend_idx_reg] && count_reg[pend_idx_reg] >= CW'(2))
        else $error("waiter refill for an entry without a second waiter");

    a_revoke_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.send_revoke |->
            result.status == clmq_pkg::STATUS_RETRY || result.send_retry)
        else $error("revoke outside a queued acquire or a handover");

    a_refill_once: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |=> !pend_reg || $past(fire))
        else $error("refill raised without an item");

endmodule

// File: rtl/cached_lock_manager_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cached_lock_manager_queue
// FIFO lock manager with revoke and retry signalling, one request per cycle unless the output backs up.
// ----------------------------------------------------------------------------
// Takes one acquire or release request per clock and answers each with one
// result item: while the request sits in the input register, the 16-way
// key match and the queue update run, and the answer is loaded into the
// output register on the edge at which the request advances. The
// combinational key match over the lock table sets the clock this design
// reaches. The input side keeps accepting while an answer waits on the output
// side; it stalls only when both registers are full and the answer is not
// being taken.
module cached_lock_manager_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  clmq_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output clmq_pkg::out_item_t m_item
);

    clmq_pkg::in_item_t  in_reg;
    logic                in_valid_reg;
    clmq_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    clmq_pkg::out_item_t result;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_reg;

    clmq_lock_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_item;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

endmodule

// File: dv/tb_cached_lock_manager_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cached_lock_manager_queue
// Self-checking bench for the FIFO lock manager with revoke and retry.
// ----------------------------------------------------------------------------
// Acquire and release requests go in over the s_ channel. A lock table
// predictor inside the scoreboard turns each accepted request into the
// answer the block owes. Answers taken from the m_ channel are compared
// field by field, in order. A short directed run walks the grant, queue,
// revoke and retry paths first. Random phases then follow, over small and
// large key pools, to reach queue-full, table-full, queue wrap and unknown
// releases. Both sides idle in short random bursts. Once in the run the
// receiver holds off long enough to back the block up.
// ----------------------------------------------------------------------------

class lock_answer_board;

    bit                          held      [clmq_pkg::LOCK_ENTRIES];
    logic [63:0]                 key_of    [clmq_pkg::LOCK_ENTRIES];
    logic [7:0]                  waiters   [clmq_pkg::LOCK_ENTRIES][clmq_pkg::WAITER_DEPTH];
    int unsigned                 head_pos  [clmq_pkg::LOCK_ENTRIES];
    int unsigned                 queue_len [clmq_pkg::LOCK_ENTRIES];
    clmq_pkg::out_item_t         due_answers[$];

    int mismatches;
    int requests_noted;
    int answers_checked;
    int table_full_hits;
    int queue_full_hits;
    int revokes_due;
    int retries_due;
    int unknown_releases;

    function new();
        for (int e = 0; e < clmq_pkg::LOCK_ENTRIES; e++) begin
            held[e]      = 1'b0;
            key_of[e]    = '0;
            head_pos[e]  = 0;
            queue_len[e] = 0;
        end
        mismatches       = 0;
        requests_noted   = 0;
        answers_checked  = 0;
        table_full_hits  = 0;
        queue_full_hits  = 0;
        revokes_due      = 0;
        retries_due      = 0;
        unknown_releases = 0;
    endfunction

    // Lock table update for one request; returns the answer it owes
    function clmq_pkg::out_item_t grant_answer(clmq_pkg::in_item_t rq);
        clmq_pkg::out_item_t ans;
        int hit;
        int spare;
        hit   = -1;
        spare = -1;
        ans   = '0;
        ans.status = clmq_pkg::STATUS_OK;
        for (int e = clmq_pkg::LOCK_ENTRIES - 1; e >= 0; e--) begin
            if (held[e] && key_of[e] == rq.lock_id) begin
                hit = e;
            end
            if (!held[e]) begin
                spare = e;
            end
        end
        if (rq.operation == clmq_pkg::OP_ACQUIRE) begin
            if (hit < 0) begin
                if (spare < 0) begin
                    ans.status = clmq_pkg::STATUS_FULL;
                    table_full_hits++;
                end else begin
                    held[spare]       = 1'b1;
                    key_of[spare]     = rq.lock_id;
                    head_pos[spare]   = 0;
                    queue_len[spare]  = 1;
                    waiters[spare][0] = rq.client_index;
                    ans.target_client = rq.client_index;
                end
            end else if (queue_len[hit] >= clmq_pkg::WAITER_DEPTH) begin
                ans.status = clmq_pkg::STATUS_FULL;
                queue_full_hits++;
            end else begin
                waiters[hit][(head_pos[hit] + queue_len[hit]) % clmq_pkg::WAITER_DEPTH] =
                    rq.client_index;
                queue_len[hit]++;
                ans.target_client = waiters[hit][head_pos[hit]];
                if (queue_len[hit] > 1) begin
                    ans.status = clmq_pkg::STATUS_RETRY;
                    ans.send_revoke = (queue_len[hit] == 2);
                end
            end
        end else if (hit >= 0) begin
            // pop the head whoever asks
            head_pos[hit] = (head_pos[hit] + 1) % clmq_pkg::WAITER_DEPTH;
            queue_len[hit]--;
            if (queue_len[hit] > 0) begin
                ans.target_client = waiters[hit][head_pos[hit]];
                ans.send_retry    = 1'b1;
                ans.send_revoke   = (queue_len[hit] > 1);
            end else begin
                held[hit]      = 1'b0;
                head_pos[hit]  = 0;
                queue_len[hit] = 0;
            end
        end else begin
            unknown_releases++;
        end
        if (ans.send_revoke) revokes_due++;
        if (ans.send_retry) retries_due++;
        return ans;
    endfunction

    function void note_request(clmq_pkg::in_item_t rq);
        requests_noted++;
        due_answers = {due_answers, grant_answer(rq)};
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_answer(clmq_pkg::out_item_t got);
        clmq_pkg::out_item_t want;
        if (due_answers.size() == 0) begin
            report_mismatch($sformatf("answer %0h with nothing outstanding", got));
        end else begin
            want = due_answers[0];
            due_answers.delete(0);
            answers_checked++;
            if (got.status !== want.status)
                report_mismatch($sformatf("answer %0d status %0d, want %0d",
                                answers_checked, got.status, want.status));
            if (got.send_revoke !== want.send_revoke)
                report_mismatch($sformatf("answer %0d send_revoke %0b, want %0b",
                                answers_checked, got.send_revoke, want.send_revoke));
            if (got.send_retry !== want.send_retry)
                report_mismatch($sformatf("answer %0d send_retry %0b, want %0b",
                                answers_checked, got.send_retry, want.send_retry));
            if (got.target_client !== want.target_client)
                report_mismatch($sformatf("answer %0d target_client %0d, want %0d",
                                answers_checked, got.target_client, want.target_client));
        end
    endtask

    task check_leftovers();
        if (due_answers.size() != 0) begin
            report_mismatch($sformatf("%0d answers never arrived", due_answers.size()));
        end
    endtask

endclass

module tb_cached_lock_manager_queue;

    localparam int RANDOM_REQUESTS = 1930;
    localparam int QUIET_TAIL      = 300;
    localparam int PHASE_LEN       = 120;
    localparam int POOL_SIZE       = 24;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    clmq_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    clmq_pkg::out_item_t m_item;

    lock_answer_board board;

    logic [63:0] key_pool [POOL_SIZE];
    bit          sender_gaps;
    bit          receiver_stalls;
    bit          long_hold_req;
    int          hold_left;
    int          drain_cycles;

    cached_lock_manager_queue DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic clmq_pkg::in_item_t make_request(logic op, logic [63:0] key,
                                                        logic [7:0] client);
        clmq_pkg::in_item_t rq;
        rq.operation    = op;
        rq.lock_id      = key;
        rq.client_index = client;
        return rq;
    endfunction

    // Mostly pool keys with a given acquire bias; a little noise on fresh keys
    function automatic clmq_pkg::in_item_t pick_request(int pool_span, int acquire_pct);
        logic op;
        logic [63:0] key;
        if ($urandom_range(0, 99) < 5) begin
            op  = $urandom_range(0, 1) ? clmq_pkg::OP_RELEASE : clmq_pkg::OP_ACQUIRE;
            key = {$urandom, $urandom};
        end else begin
            op  = ($urandom_range(0, 99) < acquire_pct) ? clmq_pkg::OP_ACQUIRE
                                                        : clmq_pkg::OP_RELEASE;
            key = key_pool[$urandom_range(0, pool_span - 1)];
        end
        return make_request(op, key, 8'($urandom_range(0, 255)));
    endfunction

    // Hold the item until it is taken, then note it
    task automatic offer_request(clmq_pkg::in_item_t rq);
        int gap;
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_item  <= rq;
        s_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_request(rq);
    endtask

    // Receiver: take answers, stall in bursts, and hold off once for a long stretch
    initial begin
        m_ready   <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                board.check_answer(m_item);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = 59;
                m_ready <= 1'b0;
            end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #3_000_000;
        $display("cached_lock_manager_queue regression: fail");
        $finish;
    end

    initial begin
        int pool_span;
        int acquire_pct;
        board           = new();
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        long_hold_req   = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++) begin
            key_pool[k] = {$urandom, $urandom};
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // grant, queue, revoke and retry on the all-zero key
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, 64'h0, 8'h00));
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, 64'h0, 8'hFF));
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, 64'h0, 8'h00));
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, 64'h0, 8'h5A));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h0, 8'hC3));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h0, 8'h11));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h0, 8'h5A));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h0, 8'h00));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h0, 8'h00));
        // key extremes and alternating bit patterns
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, '1, 8'h80));
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, 64'h5555_5555_5555_5555, 8'h01));
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, 64'hAAAA_AAAA_AAAA_AAAA, 8'hFE));
        offer_request(make_request(clmq_pkg::OP_ACQUIRE, '1, 8'h7F));
        offer_request(make_request(clmq_pkg::OP_RELEASE, '1, 8'h80));
        offer_request(make_request(clmq_pkg::OP_RELEASE, '1, 8'h7F));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h5555_5555_5555_5555, 8'hAA));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55));
        offer_request(make_request(clmq_pkg::OP_RELEASE, 64'h1234_5678_9ABC_DEF0, 8'h00));

        pool_span   = 2;
        acquire_pct = 80;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if (i % PHASE_LEN == 0 && i != 0) begin
                // second phase floods many keys to fill the table
                if (i == PHASE_LEN) begin
                    pool_span   = POOL_SIZE;
                    acquire_pct = 80;
                end else begin
                    case ($urandom_range(0, 4))
                        0: pool_span = 2;
                        1: pool_span = 3;
                        2: pool_span = 6;
                        3: pool_span = 20;
                        default: pool_span = POOL_SIZE;
                    endcase
                    acquire_pct = $urandom_range(30, 80);
                end
            end
            if (i == 400) begin
                long_hold_req = 1'b1;
            end
            if (i == RANDOM_REQUESTS - QUIET_TAIL) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            offer_request(pick_request(pool_span, acquire_pct));
        end
        s_valid <= 1'b0;

        drain_cycles = 0;
        while (board.due_answers.size() != 0 && drain_cycles < 2000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (20) @(posedge aclk);
        board.check_leftovers();

        $display("covered %0d requests, %0d answers: %0d table full, %0d queue full",
                 board.requests_noted, board.answers_checked,
                 board.table_full_hits, board.queue_full_hits);
        $display("messages owed: %0d revokes, %0d retries; %0d releases of unknown locks",
                 board.revokes_due, board.retries_due, board.unknown_releases);
        if (board.mismatches == 0) begin
            $display("cached_lock_manager_queue regression: pass");
        end else begin
            $display("cached_lock_manager_queue regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/clmq_pkg.sv
rtl/clmq_lock_table.sv
rtl/cached_lock_manager_queue.sv
dv/tb_cached_lock_manager_queue.sv
